FILE: rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

  // Command codes
  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Marker for "no value": all ones
  localparam logic signed [31:0] EMPTY_MARK = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic signed [31:0] top_value;
    logic [3:0]         entry_count;
    logic [1:0]         status;
  } out_item_t;

  // Sequencer to scan unit
  typedef struct packed {
    logic clear;
    logic data_vld;
  } scan_ctrl_t;

  // Scan unit to sequencer
  typedef struct packed {
    logic hit_seen;
    logic shift_wr;
    logic any_next;
  } scan_stat_t;

endpackage

FILE: rtl/mpq_scan.sv
`timescale 1ns / 1ps

// Shared compare unit: one stored entry per cycle. Finds the first entry equal
// to the key (the entry being removed), flags later entries for the shift down,
// and keeps the earliest largest of the remaining entries.
module mpq_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpq_pkg::scan_ctrl_t ctrl_i,
  input  logic signed [31:0] data_i,
  input  logic signed [31:0] key_i,
  output mpq_pkg::scan_stat_t stat_o,
  output logic signed [31:0] best_o
);
  import mpq_pkg::*;

  logic               found_q, found_d;
  logic               any_q, any_d;
  logic signed [31:0] best_q, best_d;
  logic               hit;
  logic               take;

  // First match of the key is the removed entry; it is left out of the max
  assign hit  = ctrl_i.data_vld & ~found_q & (data_i == key_i);
  assign take = ctrl_i.data_vld & ~hit & (~any_q | (data_i > best_q));

  always_comb begin
    if (ctrl_i.clear) begin
      found_d = 1'b0;
      any_d   = 1'b0;
    end else begin
      found_d = found_q | hit;
      any_d   = any_q | (ctrl_i.data_vld & ~hit);
    end
    best_d = take ? data_i : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      found_q <= found_d;
      any_q   <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign stat_o.hit_seen = found_q | hit;
  assign stat_o.shift_wr = ctrl_i.data_vld & found_q;
  assign stat_o.any_next = any_d;
  assign best_o          = best_d;

endmodule

FILE: rtl/max_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                              Item
// input     in   in_valid_i, in_stall_o, in_item_i    command, value
// output    out  out_valid_o, out_stall_i, out_item_o removed, top, count, status
//
// Enqueue, full drop and empty dequeue go from accept straight to publish. Other
// dequeues first make one pass over the entry memory (one read a cycle) that finds
// the removed entry, shifts the later ones down and recomputes the largest value.
// Reset clears the count and the control state; entry contents stay undefined.
// A result waits in the output register while out_stall_i is high; the next item
// is accepted meanwhile and held at its end until the register frees up.
module max_priority_queue_core #(
  parameter int DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mpq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpq_pkg::out_item_t out_item_o
);
  import mpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      occ_q, occ_d;
  logic signed [31:0] top_q, top_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic signed [31:0] removed_q, removed_d;
  logic [1:0]         status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  // Entry memory, arrival order
  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] mem_rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata;

  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;
  logic signed [31:0] scan_best;

  logic               accept;
  logic               last_data;
  logic               publish;
  logic [CW+3:0]      count_ext;

  assign accept    = in_valid_i & (state_q == S_IDLE);
  assign last_data = rd_vld_q & (CW'(rd_idx_q) == (occ_q - 1'b1));
  assign publish   = (state_q == S_FINISH) & (~out_valid_q | ~out_stall_i);

  mpq_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .data_i (mem_rdata_q),
    .key_i  (top_q),
    .stat_o (scan_stat),
    .best_o (scan_best)
  );

  // Sequencer
  always_comb begin
    state_d         = state_q;
    occ_d           = occ_q;
    top_d           = top_q;
    rd_cnt_d        = rd_cnt_q;
    rd_vld_d        = 1'b0;
    rd_idx_d        = rd_idx_q;
    removed_d       = removed_q;
    status_d        = status_q;
    mem_we          = 1'b0;
    mem_waddr       = occ_q[AW-1:0];
    mem_wdata       = in_item_i.value;
    mem_re          = 1'b0;
    mem_raddr       = rd_cnt_q[AW-1:0];
    scan_ctrl.clear    = 1'b0;
    scan_ctrl.data_vld = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          removed_d = EMPTY_MARK;
          status_d  = ST_OK;
          state_d   = S_FINISH;
          if (in_item_i.command == CMD_DEQUEUE) begin
            if (occ_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              // cached top is the value leaving
              removed_d       = top_q;
              rd_cnt_d        = '0;
              scan_ctrl.clear = 1'b1;
              state_d         = S_SCAN;
            end
          end else begin
            if (occ_q == CW'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              mem_we = 1'b1;
              occ_d  = occ_q + 1'b1;
              if ((occ_q == '0) || (in_item_i.value > top_q)) begin
                top_d = in_item_i.value;
              end
            end
          end
        end
      end
      S_SCAN: begin
        // issue one read per cycle
        if (rd_cnt_q < occ_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_cnt_q[AW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // consume the returned entry; later entries move down one place
        scan_ctrl.data_vld = rd_vld_q;
        if (scan_stat.shift_wr) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q - 1'b1;
          mem_wdata = mem_rdata_q;
        end
        if (last_data) begin
          occ_d    = occ_q - 1'b1;
          top_d    = scan_stat.any_next ? scan_best : top_q;
          rd_vld_d = 1'b0;
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (publish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  assign count_ext = {4'b0, occ_q};
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_item_d  = out_item_q;
    if (publish) begin
      out_valid_d              = 1'b1;
      out_item_d.removed_value = removed_q;
      out_item_d.top_value     = (occ_q == '0) ? EMPTY_MARK : top_q;
      out_item_d.entry_count   = count_ext[3:0];
      out_item_d.status        = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    rd_idx_q   <= rd_idx_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
    out_item_q <= out_item_d;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_removed_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && last_data |-> scan_stat.hit_seen)
    else $error("dequeue pass ended without finding the top entry");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_item_i.command == CMD_ENQUEUE) && (occ_q != CW'(DEPTH))
    |=> occ_q == $past(occ_q) + 1'b1)
    else $error("enqueue did not grow the count");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    publish |=> out_valid_q && (state_q == S_IDLE))
    else $error("result not loaded on publish");

endmodule
